FILE: rtl/psrd_pkg.sv
// ----------------------------------------------------------------------------
// psrd_pkg: shared types and constants of the point store
// Transaction types for both channels, the token that travels the cell chain
// and the sizes of the store.
// ----------------------------------------------------------------------------
package psrd_pkg;

  localparam int unsigned SLOTS      = 64;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned CNT_W      = $clog2(SLOTS + 1);
  localparam int unsigned DIST_W     = 2 * COORD_BITS + 2;

  localparam logic [31:0] RADIUS_SQ_RESET = 32'd10000;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic                         command;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [5:0]                   slot_index;
  } in_item_t;

  typedef struct packed {
    logic                         entry_valid;
    logic signed [COORD_BITS-1:0] entry_x;
    logic signed [COORD_BITS-1:0] entry_y;
    logic signed [COORD_BITS-1:0] entry_z;
    logic [6:0]                   points_kept;
    logic [6:0]                   removed_count;
    logic                         dropped;
  } out_item_t;

  typedef struct packed {
    logic                         active;
    logic                         command;
    logic [5:0]                   slot_index;
    logic                         placed;
    logic [CNT_W-1:0]             removed;
    logic [CNT_W-1:0]             kept;
    logic                         entry_valid;
    logic signed [COORD_BITS-1:0] entry_x;
    logic signed [COORD_BITS-1:0] entry_y;
    logic signed [COORD_BITS-1:0] entry_z;
  } tok_t;

endpackage

FILE: rtl/psrd_cell.sv
// ----------------------------------------------------------------------------
// psrd_cell: one slot of the point store
// Holds one point and its valid bit, measures the squared distance to the
// broadcast point over three registered stages and updates the passing token.
// ----------------------------------------------------------------------------
module psrd_cell
  import psrd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  in_item_t         pt_i,
  input  logic [31:0]      radius_sq_i,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic                         valid_q, valid_d;
  logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
  logic                         wr_en;

  logic signed [COORD_BITS:0]   dx, dy, dz;
  logic [COORD_BITS-1:0]        ax_d, ay_d, az_d, ax_q, ay_q, az_q;
  logic [2*COORD_BITS-1:0]      sx_d, sy_d, sz_d, sx_q, sy_q, sz_q;
  logic [DIST_W-1:0]            dist_sq;
  logic                         dup_d, dup_q;
  logic                         keep;
  tok_t                         tok_d, tok_q;

  always_comb begin
    dx = $signed({pt_i.point_x[COORD_BITS-1], pt_i.point_x}) - $signed({x_q[COORD_BITS-1], x_q});
    dy = $signed({pt_i.point_y[COORD_BITS-1], pt_i.point_y}) - $signed({y_q[COORD_BITS-1], y_q});
    dz = $signed({pt_i.point_z[COORD_BITS-1], pt_i.point_z}) - $signed({z_q[COORD_BITS-1], z_q});
    ax_d = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay_d = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    az_d = dz[COORD_BITS] ? COORD_BITS'(-dz) : COORD_BITS'(dz);
    sx_d = ax_q * ax_q;
    sy_d = ay_q * ay_q;
    sz_d = az_q * az_q;
    dist_sq = DIST_W'(sx_q) + DIST_W'(sy_q) + DIST_W'(sz_q);
    dup_d = dist_sq < DIST_W'(radius_sq_i);
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    az_q  <= az_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    sz_q  <= sz_d;
    dup_q <= dup_d;
  end

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    wr_en   = 1'b0;
    keep    = 1'b0;
    if (tok_i.active) begin
      if (tok_i.command == CMD_INSERT) begin
        keep = valid_q && !dup_q;
        if (valid_q && dup_q) begin
          tok_d.removed = tok_i.removed + CNT_W'(1);
        end
        if (!keep && !tok_i.placed) begin
          wr_en        = 1'b1;
          keep         = 1'b1;
          tok_d.placed = 1'b1;
        end
        valid_d    = keep;
        tok_d.kept = tok_i.kept + CNT_W'(keep);
      end else begin
        if ((32'(tok_i.slot_index) == 32'(cell_idx_i)) && valid_q) begin
          tok_d.entry_valid = 1'b1;
          tok_d.entry_x     = x_q;
          tok_d.entry_y     = y_q;
          tok_d.entry_z     = z_q;
        end
        tok_d.kept = tok_i.kept + CNT_W'(valid_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_q <= pt_i.point_x;
      y_q <= pt_i.point_y;
      z_q <= pt_i.point_z;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: rtl/point_store_radius_dedup_top.sv
// ----------------------------------------------------------------------------
// point_store_radius_dedup_top: point store with radius duplicate removal
// Keeps SLOTS points in a chain of cells; an insert removes every stored point
// closer than the radius and takes the lowest free slot, a read returns a slot.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. An insert first lets every cell form its
// squared distance (difference, square, sum and compare) in the states DIFF,
// SQ and CMP, then a token walks the chain one cell per cycle to remove, place
// and count; a read skips those states and starts with the walk. The result of
// the walk passes through a result register to a free output register. A
// finished result waits in the output register while the next transaction is
// accepted. No clearing pass follows reset.
module point_store_radius_dedup_top
  import psrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_INJ  = 3'd4;
  localparam logic [2:0] ST_RUN  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [31:0] radius_sq_q;
  in_item_t    item_q;
  out_item_t   res_q, res_d, out_q;
  logic        res_pend_q, out_valid_q;
  logic        in_fire, res_move, tok_done;
  tok_t        tok_inj;
  tok_t        chain [SLOTS+1];
  logic [SLOTS-1:0] tok_act;

  assign in_ready_o = (state_q == ST_IDLE) && !res_pend_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign tok_done   = chain[SLOTS].active;
  assign res_move   = res_pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    tok_inj            = '0;
    tok_inj.active     = (state_q == ST_INJ);
    tok_inj.command    = item_q.command;
    tok_inj.slot_index = item_q.slot_index;
  end

  assign chain[0] = tok_inj;

  genvar g;
  for (g = 0; g < SLOTS; g++) begin : g_cell
    psrd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IDX_W'(g)),
      .pt_i        (item_q),
      .radius_sq_i (radius_sq_q),
      .tok_i       (chain[g]),
      .tok_o       (chain[g+1])
    );
    assign tok_act[g] = chain[g+1].active;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.command == CMD_READ) ? ST_INJ : ST_DIFF;
        end
      end
      ST_DIFF: state_d = ST_SQ;
      ST_SQ:   state_d = ST_CMP;
      ST_CMP:  state_d = ST_INJ;
      ST_INJ:  state_d = ST_RUN;
      ST_RUN: begin
        if (tok_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_d               = '0;
    res_d.entry_valid   = chain[SLOTS].entry_valid;
    res_d.entry_x       = chain[SLOTS].entry_x;
    res_d.entry_y       = chain[SLOTS].entry_y;
    res_d.entry_z       = chain[SLOTS].entry_z;
    res_d.points_kept   = 7'(chain[SLOTS].kept);
    if (chain[SLOTS].command == CMD_INSERT) begin
      res_d.removed_count = 7'(chain[SLOTS].removed);
      res_d.dropped       = !chain[SLOTS].placed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_sq_q <= RADIUS_SQ_RESET;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        radius_sq_q <= cfg_wdata_i;
      end
      if (tok_done) begin
        res_pend_q <= 1'b1;
      end else if (res_move) begin
        res_pend_q <= 1'b0;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= res_pend_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (tok_done) begin
      res_q <= res_d;
    end
    if (res_move) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_act) <= 1)
    else $error("more than one token in the cell chain");

  a_exit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_done |-> (state_q == ST_RUN) && !res_pend_q)
    else $error("token left the chain outside the run state");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_DIFF) || (state_q == ST_INJ))
    else $error("accepted transaction did not start work");

  a_kept_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_pend_q |-> (32'(res_q.points_kept) <= SLOTS))
    else $error("kept count exceeds store size");

endmodule

FILE: dv/point_store_radius_dedup_top_tb.sv
// ----------------------------------------------------------------------------
// point_store_radius_dedup_top_tb: self-checking bench of the point store
// Drives insert and read transactions through the valid/ready input channel,
// rewrites the duplicate radius between phases and compares every result
// against a cycle-free model of the store kept in the bench itself.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_store_radius_dedup_top_tb;
  import psrd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 80;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  point_store_radius_dedup_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic signed [COORD_BITS-1:0] store_x [SLOTS];
  logic signed [COORD_BITS-1:0] store_y [SLOTS];
  logic signed [COORD_BITS-1:0] store_z [SLOTS];
  bit                           store_live [SLOTS];
  bit                           store_written [SLOTS];
  int unsigned                  written_slots [$];
  logic [31:0]                  radius_sq_model = RADIUS_SQ_RESET;

  out_item_t   pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned insert_count   = 0;
  int unsigned read_count     = 0;
  int unsigned drop_count     = 0;
  int unsigned removed_total  = 0;
  int unsigned radius_writes  = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("point_store_radius_dedup_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) < recv_idle_pct) ? 1'b0 : 1'b1;
  end

  function automatic logic [63:0] sq_gap(logic signed [COORD_BITS-1:0] a,
                                         logic signed [COORD_BITS-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic out_item_t apply_point_cmd(in_item_t item);
    out_item_t   res;
    logic [63:0] dist_sq;
    int unsigned removed;
    int unsigned kept;
    bit          placed;
    res     = '0;
    removed = 0;
    kept    = 0;
    placed  = 1'b0;
    if (item.command == CMD_INSERT) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (store_live[i]) begin
          dist_sq = sq_gap(item.point_x, store_x[i]) + sq_gap(item.point_y, store_y[i])
                  + sq_gap(item.point_z, store_z[i]);
          if (dist_sq < {32'd0, radius_sq_model}) begin
            store_live[i] = 1'b0;
            removed++;
          end
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !store_live[i]) begin
          store_x[i]    = item.point_x;
          store_y[i]    = item.point_y;
          store_z[i]    = item.point_z;
          store_live[i] = 1'b1;
          placed        = 1'b1;
          if (!store_written[i]) begin
            store_written[i] = 1'b1;
            written_slots    = {written_slots, i};
          end
        end
      end
      res.removed_count = removed[6:0];
      res.dropped       = !placed;
    end else if (item.slot_index < SLOTS && store_live[item.slot_index]) begin
      res.entry_valid = 1'b1;
      res.entry_x     = store_x[item.slot_index];
      res.entry_y     = store_y[item.slot_index];
      res.entry_z     = store_z[item.slot_index];
    end
    for (int i = 0; i < SLOTS; i++) kept += store_live[i];
    res.points_kept = kept[6:0];
    return res;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("entry_valid", want.entry_valid, out_data_o.entry_valid);
        check_field("entry_x", want.entry_x, out_data_o.entry_x);
        check_field("entry_y", want.entry_y, out_data_o.entry_y);
        check_field("entry_z", want.entry_z, out_data_o.entry_z);
        check_field("points_kept", want.points_kept, out_data_o.points_kept);
        check_field("removed_count", want.removed_count, out_data_o.removed_count);
        check_field("dropped", want.dropped, out_data_o.dropped);
      end
    end
  end

  function automatic in_item_t point_cmd(logic cmd, int x, int y, int z, int idx);
    in_item_t item;
    item.command    = cmd;
    item.point_x    = x[COORD_BITS-1:0];
    item.point_y    = y[COORD_BITS-1:0];
    item.point_z    = z[COORD_BITS-1:0];
    item.slot_index = idx[5:0];
    return item;
  endfunction

  task automatic send_point_cmd(in_item_t item);
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    res = apply_point_cmd(item);
    pending_results = {pending_results, res};
    if (item.command == CMD_INSERT) begin
      insert_count++;
      drop_count    += res.dropped;
      removed_total += res.removed_count;
    end else begin
      read_count++;
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_radius(logic [31:0] value);
    wait_for_results();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    radius_sq_model = value;
    radius_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_point_cmd(point_cmd(CMD_INSERT, 0, 0, 0, 63));
    send_point_cmd(point_cmd(CMD_READ, 0, 0, 0, 0));
    send_point_cmd(point_cmd(CMD_INSERT, 0, 0, 0, 0));
    send_point_cmd(point_cmd(CMD_INSERT, 100, 0, 0, 21));
    send_point_cmd(point_cmd(CMD_INSERT, 32767, 32767, 32767, 42));
    send_point_cmd(point_cmd(CMD_INSERT, -32768, -32768, -32768, 63));
    send_point_cmd(point_cmd(CMD_INSERT, 32767, -32768, 0, 0));
    send_point_cmd(point_cmd(CMD_INSERT, -32768, 32767, -1, 5));
    send_point_cmd(point_cmd(CMD_INSERT, 0, 99, 0, 7));
    send_point_cmd(point_cmd(CMD_INSERT, 32767, 32767, 32668, 0));
    send_point_cmd(point_cmd(CMD_INSERT, 50, 1, 1, 0));
    for (int i = 0; i < 7; i++) send_point_cmd(point_cmd(CMD_READ, -1, -1, -1, i));
    send_point_cmd(point_cmd(CMD_READ, 32767, 32767, 32767, 1));
  endtask

  task automatic test_store_full();
    int k;
    write_radius(32'd0);
    for (int i = 0; i < 66; i++) begin
      send_point_cmd(point_cmd(CMD_INSERT, $urandom_range(65535), $urandom_range(65535),
                               $urandom_range(65535), $urandom_range(63)));
    end
    send_point_cmd(point_cmd(CMD_INSERT, store_x[3], store_y[3], store_z[3], 3));
    for (int i = 0; i < SLOTS; i++) send_point_cmd(point_cmd(CMD_READ, 0, 0, 0, i));
    write_radius(32'd1);
    k = $urandom_range(SLOTS - 1);
    send_point_cmd(point_cmd(CMD_INSERT, store_x[k], store_y[k], store_z[k], k));
    send_point_cmd(point_cmd(CMD_INSERT, store_x[k] + 1, store_y[k], store_z[k], k));
    write_radius(32'hFFFF_FFFF);
    send_point_cmd(point_cmd(CMD_INSERT, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_point_cmd(point_cmd(CMD_READ, 0, 0, 0, i));
  endtask

  task automatic test_random(int unsigned count, logic [31:0] radius, int span, bit hold_off);
    in_item_t item;
    int       cx;
    int       cy;
    int       cz;
    write_radius(radius);
    cx = $urandom_range(65535) - 32768;
    cy = $urandom_range(65535) - 32768;
    cz = $urandom_range(65535) - 32768;
    for (int n = 0; n < count; n++) begin
      if (hold_off && (n % 40) == 39) wait_for_results();
      if (written_slots.size() == 0 || $urandom_range(99) < 70) begin
        if ($urandom_range(99) < 10) begin
          item = point_cmd(CMD_INSERT, $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(63));
        end else begin
          item = point_cmd(CMD_INSERT, cx + $urandom_range(2 * span) - span,
                           cy + $urandom_range(2 * span) - span,
                           cz + $urandom_range(2 * span) - span, $urandom_range(63));
        end
      end else begin
        item = point_cmd(CMD_READ, $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(65535),
                         written_slots[$urandom_range(written_slots.size() - 1)]);
      end
      send_point_cmd(item);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      store_live[i]    = 1'b0;
      store_written[i] = 1'b0;
    end
    send_idle_pct = 10;
    recv_idle_pct = 81;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_store_full();
    test_random(240, RADIUS_SQ_RESET, 300, 1'b0);
    test_random(240, RADIUS_SQ_RESET, 2000, 1'b1);

    send_idle_pct = 81;
    recv_idle_pct = 10;
    test_random(200, 32'd1, 3, 1'b0);
    test_random(200, $urandom_range(32'd4_000_000), 2500, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150, 32'hFFFF_FFFF, 20000, 1'b0);
    test_random(240, 32'd0, 200, 1'b1);
    test_random(130, $urandom, 30000, 1'b0);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d inserts (%0d dropped, %0d duplicates removed) and %0d reads",
             insert_count, drop_count, removed_total, read_count);
    $display("under %0d radius writes and three idle patterns", radius_writes);
    if (mismatch_count == 0) begin
      $display("point_store_radius_dedup_top_tb: clean");
    end else begin
      $display("point_store_radius_dedup_top_tb: errors");
    end
    $finish;
  end

endmodule
